// ===== src/dpec_pkg.sv =====
// ----------------------------------------------------------------------------
// dpec_pkg
// Shared types, stage counts and helpers for the disk pair collision pipeline.
// ----------------------------------------------------------------------------
package dpec_pkg;

    localparam int SQRT_STAGES = 25;   // one root bit per stage
    localparam int NDIV_STAGES = 29;   // normal quotient bits, Q1.28
    localparam int KDIV_STAGES = 36;   // impulse quotient bits
    localparam int NORM_FRAC   = 28;

    // geometry and pass-through state, carried from the front end through the normal divider to stage G
    typedef struct packed {
        logic [31:0] apx;
        logic [31:0] apy;
        logic [31:0] avx;
        logic [31:0] avy;
        logic [31:0] bpx;
        logic [31:0] bpy;
        logic [31:0] bvx;
        logic [31:0] bvy;
        logic [15:0] am;
        logic [15:0] bm;
        logic [32:0] dvxm;
        logic [32:0] dvym;
        logic        dvxn;
        logic        dvyn;
        logic        dxn;
        logic        dyn;
        logic [24:0] adx;
        logic [24:0] ady;
        logic [24:0] mind;
        logic [24:0] ovl;
        logic        touch;
    } geo_t;

    // state carried through the impulse divider
    typedef struct packed {
        logic [31:0] avx;
        logic [31:0] avy;
        logic [31:0] bvx;
        logic [31:0] bvy;
        logic [31:0] apx_n;
        logic [31:0] apy_n;
        logic [31:0] bpx_n;
        logic [31:0] bpy_n;
        logic [28:0] nxm;
        logic [28:0] nym;
        logic        nxn;
        logic        nyn;
        logic        dotn;
        logic        touch;
        logic        bounce;
    } kpay_t;

    function automatic logic [31:0] sat32(input logic signed [39:0] v);
        logic [31:0] r;
        if (v > 40'sd2147483647) begin
            r = 32'h7fff_ffff;
        end else if (v < -40'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== src/dpec_sqrt.sv =====
// ----------------------------------------------------------------------------
// dpec_sqrt
// Pipelined integer square root, one result bit per stage, floor rounding.
// ----------------------------------------------------------------------------
module dpec_sqrt (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  logic [49:0]    in_rad,
    input  dpec_pkg::geo_t in_geo,
    output logic           out_valid,
    output logic [24:0]    out_root,
    output dpec_pkg::geo_t out_geo
);

    logic           valid_reg [dpec_pkg::SQRT_STAGES];
    logic [49:0]    rad_reg   [dpec_pkg::SQRT_STAGES];
    logic [25:0]    rem_reg   [dpec_pkg::SQRT_STAGES];
    logic [24:0]    root_reg  [dpec_pkg::SQRT_STAGES];
    dpec_pkg::geo_t geo_reg   [dpec_pkg::SQRT_STAGES];

    for (genvar k = 0; k < dpec_pkg::SQRT_STAGES; k++) begin : g_stage
        logic           v_in;
        logic [49:0]    rad_in;
        logic [25:0]    rem_in;
        logic [24:0]    root_in;
        dpec_pkg::geo_t geo_in;
        logic [26:0]    rem_sh;
        logic [26:0]    trial;
        logic           take;

        if (k == 0) begin : g_head
            assign v_in    = in_valid;
            assign rad_in  = in_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign geo_in  = in_geo;
        end else begin : g_body
            assign v_in    = valid_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign geo_in  = geo_reg[k-1];
        end

        // bring down the next pair of radicand bits
        assign rem_sh = {rem_in[24:0], rad_in[2*(dpec_pkg::SQRT_STAGES-1-k) +: 2]};
        assign trial  = {root_in, 2'b01};
        assign take   = rem_sh >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[k]  <= rad_in;
                rem_reg[k]  <= take ? 26'(rem_sh - trial) : rem_sh[25:0];
                root_reg[k] <= {root_in[23:0], take};
                geo_reg[k]  <= geo_in;
            end
        end
    end

    assign out_valid = valid_reg[dpec_pkg::SQRT_STAGES-1];
    assign out_root  = root_reg[dpec_pkg::SQRT_STAGES-1];
    assign out_geo   = geo_reg[dpec_pkg::SQRT_STAGES-1];

endmodule

// ===== src/dpec_ndiv.sv =====
// ----------------------------------------------------------------------------
// dpec_ndiv
// Pipelined restoring divider for the contact normal, both axes side by side.
// ----------------------------------------------------------------------------
module dpec_ndiv (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  logic [24:0]    in_dist,
    input  dpec_pkg::geo_t in_geo,
    output logic           out_valid,
    output logic [28:0]    out_nxm,
    output logic [28:0]    out_nym,
    output dpec_pkg::geo_t out_geo
);

    logic           valid_reg [dpec_pkg::NDIV_STAGES];
    logic [24:0]    dist_reg  [dpec_pkg::NDIV_STAGES];
    logic [24:0]    rx_reg    [dpec_pkg::NDIV_STAGES];
    logic [24:0]    ry_reg    [dpec_pkg::NDIV_STAGES];
    logic [28:0]    qx_reg    [dpec_pkg::NDIV_STAGES];
    logic [28:0]    qy_reg    [dpec_pkg::NDIV_STAGES];
    dpec_pkg::geo_t geo_reg   [dpec_pkg::NDIV_STAGES];

    for (genvar k = 0; k < dpec_pkg::NDIV_STAGES; k++) begin : g_stage
        logic           v_in;
        logic [24:0]    dist_in;
        logic [28:0]    qx_in;
        logic [28:0]    qy_in;
        dpec_pkg::geo_t geo_in;
        logic [25:0]    r2x;
        logic [25:0]    r2y;
        logic           tx;
        logic           ty;

        if (k == 0) begin : g_head
            // |d| <= dist, so the leading quotient bit is the integer bit
            assign v_in    = in_valid;
            assign dist_in = in_dist;
            assign qx_in   = '0;
            assign qy_in   = '0;
            assign geo_in  = in_geo;
            assign r2x     = {1'b0, in_geo.adx};
            assign r2y     = {1'b0, in_geo.ady};
        end else begin : g_body
            assign v_in    = valid_reg[k-1];
            assign dist_in = dist_reg[k-1];
            assign qx_in   = qx_reg[k-1];
            assign qy_in   = qy_reg[k-1];
            assign geo_in  = geo_reg[k-1];
            assign r2x     = {rx_reg[k-1], 1'b0};
            assign r2y     = {ry_reg[k-1], 1'b0};
        end

        assign tx = r2x >= {1'b0, dist_in};
        assign ty = r2y >= {1'b0, dist_in};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dist_reg[k] <= dist_in;
                rx_reg[k]   <= tx ? 25'(r2x - {1'b0, dist_in}) : r2x[24:0];
                ry_reg[k]   <= ty ? 25'(r2y - {1'b0, dist_in}) : r2y[24:0];
                qx_reg[k]   <= {qx_in[27:0], tx};
                qy_reg[k]   <= {qy_in[27:0], ty};
                geo_reg[k]  <= geo_in;
            end
        end
    end

    assign out_valid = valid_reg[dpec_pkg::NDIV_STAGES-1];
    assign out_nxm   = qx_reg[dpec_pkg::NDIV_STAGES-1];
    assign out_nym   = qy_reg[dpec_pkg::NDIV_STAGES-1];
    assign out_geo   = geo_reg[dpec_pkg::NDIV_STAGES-1];

endmodule

// ===== src/dpec_kdiv.sv =====
// ----------------------------------------------------------------------------
// dpec_kdiv
// Pipelined restoring divider for the two impulse magnitudes by the mass sum.
// ----------------------------------------------------------------------------
module dpec_kdiv (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  logic [51:0]     in_na,
    input  logic [51:0]     in_nb,
    input  logic [16:0]     in_msum,
    input  dpec_pkg::kpay_t in_pay,
    output logic            out_valid,
    output logic [35:0]     out_ka,
    output logic [35:0]     out_kb,
    output dpec_pkg::kpay_t out_pay
);

    logic            valid_reg [dpec_pkg::KDIV_STAGES];
    logic [51:0]     na_reg    [dpec_pkg::KDIV_STAGES];
    logic [51:0]     nb_reg    [dpec_pkg::KDIV_STAGES];
    logic [16:0]     msum_reg  [dpec_pkg::KDIV_STAGES];
    logic [16:0]     ra_reg    [dpec_pkg::KDIV_STAGES];
    logic [16:0]     rb_reg    [dpec_pkg::KDIV_STAGES];
    logic [35:0]     qa_reg    [dpec_pkg::KDIV_STAGES];
    logic [35:0]     qb_reg    [dpec_pkg::KDIV_STAGES];
    dpec_pkg::kpay_t pay_reg   [dpec_pkg::KDIV_STAGES];

    for (genvar k = 0; k < dpec_pkg::KDIV_STAGES; k++) begin : g_stage
        logic            v_in;
        logic [51:0]     na_in;
        logic [51:0]     nb_in;
        logic [16:0]     msum_in;
        logic [16:0]     ra_in;
        logic [16:0]     rb_in;
        logic [35:0]     qa_in;
        logic [35:0]     qb_in;
        dpec_pkg::kpay_t pay_in;
        logic [17:0]     r2a;
        logic [17:0]     r2b;
        logic            ta;
        logic            tb;

        if (k == 0) begin : g_head
            // quotient fits 36 bits, so the top dividend bits are below the divisor
            assign v_in    = in_valid;
            assign na_in   = in_na;
            assign nb_in   = in_nb;
            assign msum_in = in_msum;
            assign ra_in   = {1'b0, in_na[51:36]};
            assign rb_in   = {1'b0, in_nb[51:36]};
            assign qa_in   = '0;
            assign qb_in   = '0;
            assign pay_in  = in_pay;
        end else begin : g_body
            assign v_in    = valid_reg[k-1];
            assign na_in   = na_reg[k-1];
            assign nb_in   = nb_reg[k-1];
            assign msum_in = msum_reg[k-1];
            assign ra_in   = ra_reg[k-1];
            assign rb_in   = rb_reg[k-1];
            assign qa_in   = qa_reg[k-1];
            assign qb_in   = qb_reg[k-1];
            assign pay_in  = pay_reg[k-1];
        end

        assign r2a = {ra_in, na_in[dpec_pkg::KDIV_STAGES-1-k]};
        assign r2b = {rb_in, nb_in[dpec_pkg::KDIV_STAGES-1-k]};
        assign ta  = r2a >= {1'b0, msum_in};
        assign tb  = r2b >= {1'b0, msum_in};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                na_reg[k]   <= na_in;
                nb_reg[k]   <= nb_in;
                msum_reg[k] <= msum_in;
                ra_reg[k]   <= ta ? 17'(r2a - {1'b0, msum_in}) : r2a[16:0];
                rb_reg[k]   <= tb ? 17'(r2b - {1'b0, msum_in}) : r2b[16:0];
                qa_reg[k]   <= {qa_in[34:0], ta};
                qb_reg[k]   <= {qb_in[34:0], tb};
                pay_reg[k]  <= pay_in;
            end
        end
    end

    assign out_valid = valid_reg[dpec_pkg::KDIV_STAGES-1];
    assign out_ka    = qa_reg[dpec_pkg::KDIV_STAGES-1];
    assign out_kb    = qb_reg[dpec_pkg::KDIV_STAGES-1];
    assign out_pay   = pay_reg[dpec_pkg::KDIV_STAGES-1];

endmodule

// ===== src/disk_pair_elastic_collision.sv =====
// Throughput: one disk pair per cycle; the whole pipe advances together and
// holds while the output register is full and m_tready is low.
// Depth is set by the root (25), normal divider (29) and impulse divider (36).
// Reset clears every stage valid bit; payload registers are not reset.
// ----------------------------------------------------------------------------
// disk_pair_elastic_collision
// Two-disk contact resolution: overlap push-out and elastic impulse, Q16.16.
// ----------------------------------------------------------------------------
module disk_pair_elastic_collision (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // a_pos_x, a_pos_y, a_vel_x, a_vel_y, a_radius, a_mass,
    // b_pos_x, b_pos_y, b_vel_x, b_vel_y, b_radius, b_mass
    input  logic [335:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // a_new_pos_x, a_new_pos_y, a_new_vel_x, a_new_vel_y,
    // b_new_pos_x, b_new_pos_y, b_new_vel_x, b_new_vel_y
    output logic [255:0] m_tdata,
    // touching, bounced
    output logic [1:0]   m_tuser
);

    logic en;

    // input fields
    logic [31:0] s_apx, s_apy, s_avx, s_avy, s_bpx, s_bpy, s_bvx, s_bvy;
    logic [23:0] s_ar, s_br;
    logic [15:0] s_am, s_bm;

    assign s_apx = s_tdata[31:0];
    assign s_apy = s_tdata[63:32];
    assign s_avx = s_tdata[95:64];
    assign s_avy = s_tdata[127:96];
    assign s_ar  = s_tdata[151:128];
    assign s_am  = s_tdata[167:152];
    assign s_bpx = s_tdata[199:168];
    assign s_bpy = s_tdata[231:200];
    assign s_bvx = s_tdata[263:232];
    assign s_bvy = s_tdata[295:264];
    assign s_br  = s_tdata[319:296];
    assign s_bm  = s_tdata[335:320];

    // ---------------- stage A: differences ----------------
    logic           sa_valid_reg;
    dpec_pkg::geo_t sa_geo_reg, sa_geo_next;
    logic [32:0]    sa_dx_reg, sa_dy_reg, sa_dvx_reg, sa_dvy_reg;
    logic [24:0]    sa_mind_reg;

    always_comb begin
        sa_geo_next     = '0;
        sa_geo_next.apx = s_apx;
        sa_geo_next.apy = s_apy;
        sa_geo_next.avx = s_avx;
        sa_geo_next.avy = s_avy;
        sa_geo_next.bpx = s_bpx;
        sa_geo_next.bpy = s_bpy;
        sa_geo_next.bvx = s_bvx;
        sa_geo_next.bvy = s_bvy;
        sa_geo_next.am  = s_am;
        sa_geo_next.bm  = s_bm;
    end

    // ---------------- stage B: magnitudes, box test ----------------
    logic           sb_valid_reg;
    dpec_pkg::geo_t sb_geo_reg, sb_geo_next;
    logic           sb_inr_reg, sb_inr_next;
    logic [32:0]    b_dxm, b_dym;

    always_comb begin
        b_dxm = sa_dx_reg[32] ? 33'(-sa_dx_reg) : sa_dx_reg;
        b_dym = sa_dy_reg[32] ? 33'(-sa_dy_reg) : sa_dy_reg;
        sb_geo_next      = sa_geo_reg;
        sb_geo_next.dxn  = sa_dx_reg[32];
        sb_geo_next.dyn  = sa_dy_reg[32];
        sb_geo_next.adx  = b_dxm[24:0];
        sb_geo_next.ady  = b_dym[24:0];
        sb_geo_next.dvxn = sa_dvx_reg[32];
        sb_geo_next.dvyn = sa_dvy_reg[32];
        sb_geo_next.dvxm = sa_dvx_reg[32] ? 33'(-sa_dvx_reg) : sa_dvx_reg;
        sb_geo_next.dvym = sa_dvy_reg[32] ? 33'(-sa_dvy_reg) : sa_dvy_reg;
        sb_geo_next.mind = sa_mind_reg;
        sb_inr_next = (b_dxm <= {8'd0, sa_mind_reg}) && (b_dym <= {8'd0, sa_mind_reg})
                      && ((b_dxm | b_dym) != '0);
    end

    // ---------------- stage C: squares ----------------
    logic           sc_valid_reg;
    dpec_pkg::geo_t sc_geo_reg;
    logic           sc_inr_reg;
    logic [49:0]    sc_sqx_reg, sc_sqy_reg, sc_mind2_reg;

    // ---------------- stage D: radius test ----------------
    logic           sd_valid_reg;
    dpec_pkg::geo_t sd_geo_reg, sd_geo_next;
    logic [49:0]    sd_rad_reg, sd_rad_next;
    logic [50:0]    d_d2;

    always_comb begin
        d_d2              = {1'b0, sc_sqx_reg} + {1'b0, sc_sqy_reg};
        sd_geo_next       = sc_geo_reg;
        sd_geo_next.touch = sc_inr_reg && (d_d2 <= {1'b0, sc_mind2_reg});
        sd_rad_next       = sd_geo_next.touch ? d_d2[49:0] : '0;
    end

    // ---------------- root and normal ----------------
    logic           sq_valid;
    logic [24:0]    sq_root;
    dpec_pkg::geo_t sq_geo, nd_geo_in;
    logic           nd_valid;
    logic [28:0]    nd_nxm, nd_nym;
    dpec_pkg::geo_t nd_geo;

    dpec_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sd_valid_reg),
        .in_rad    (sd_rad_reg),
        .in_geo    (sd_geo_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_geo   (sq_geo)
    );

    always_comb begin
        nd_geo_in     = sq_geo;
        nd_geo_in.ovl = sq_geo.mind - sq_root;
    end

    dpec_ndiv u_ndiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_dist   (sq_root),
        .in_geo    (nd_geo_in),
        .out_valid (nd_valid),
        .out_nxm   (nd_nxm),
        .out_nym   (nd_nym),
        .out_geo   (nd_geo)
    );

    // ---------------- stage E: correction and dot products ----------------
    logic           se_valid_reg;
    dpec_pkg::geo_t se_geo_reg;
    logic [28:0]    se_nxm_reg, se_nym_reg;
    logic [53:0]    se_cxp_reg, se_cyp_reg;
    logic [61:0]    se_dxp_reg, se_dyp_reg;

    // ---------------- stage F: rounding ----------------
    logic           sf_valid_reg;
    dpec_pkg::geo_t sf_geo_reg;
    logic [28:0]    sf_nxm_reg, sf_nym_reg;
    logic [24:0]    sf_cxm_reg, sf_cym_reg;
    logic [33:0]    sf_tx_reg, sf_ty_reg;

    // ---------------- stage G: positions, dot sum ----------------
    logic            sg_valid_reg;
    dpec_pkg::kpay_t sg_pay_reg, sg_pay_next;
    logic [35:0]     sg_dot_reg, sg_dot_next;
    logic [16:0]     sg_msum_reg;
    logic [15:0]     sg_am_reg, sg_bm_reg;
    logic [35:0]     g_tx, g_ty;

    always_comb begin
        g_tx = {2'b00, sf_tx_reg};
        g_ty = {2'b00, sf_ty_reg};
        sg_dot_next = (sf_geo_reg.dvxn ^ sf_geo_reg.dxn ? 36'(-g_tx) : g_tx)
                    + (sf_geo_reg.dvyn ^ sf_geo_reg.dyn ? 36'(-g_ty) : g_ty);
        sg_pay_next        = '0;
        sg_pay_next.avx    = sf_geo_reg.avx;
        sg_pay_next.avy    = sf_geo_reg.avy;
        sg_pay_next.bvx    = sf_geo_reg.bvx;
        sg_pay_next.bvy    = sf_geo_reg.bvy;
        sg_pay_next.nxm    = sf_nxm_reg;
        sg_pay_next.nym    = sf_nym_reg;
        sg_pay_next.nxn    = sf_geo_reg.dxn;
        sg_pay_next.nyn    = sf_geo_reg.dyn;
        sg_pay_next.touch  = sf_geo_reg.touch;
        sg_pay_next.apx_n  = sf_geo_reg.apx;
        sg_pay_next.apy_n  = sf_geo_reg.apy;
        sg_pay_next.bpx_n  = sf_geo_reg.bpx;
        sg_pay_next.bpy_n  = sf_geo_reg.bpy;
        if (sf_geo_reg.touch) begin
            sg_pay_next.apx_n = dpec_pkg::sat32(sf_geo_reg.dxn
                ? $signed({{8{sf_geo_reg.apx[31]}}, sf_geo_reg.apx}) + $signed({15'd0, sf_cxm_reg})
                : $signed({{8{sf_geo_reg.apx[31]}}, sf_geo_reg.apx}) - $signed({15'd0, sf_cxm_reg}));
            sg_pay_next.apy_n = dpec_pkg::sat32(sf_geo_reg.dyn
                ? $signed({{8{sf_geo_reg.apy[31]}}, sf_geo_reg.apy}) + $signed({15'd0, sf_cym_reg})
                : $signed({{8{sf_geo_reg.apy[31]}}, sf_geo_reg.apy}) - $signed({15'd0, sf_cym_reg}));
            sg_pay_next.bpx_n = dpec_pkg::sat32(sf_geo_reg.dxn
                ? $signed({{8{sf_geo_reg.bpx[31]}}, sf_geo_reg.bpx}) - $signed({15'd0, sf_cxm_reg})
                : $signed({{8{sf_geo_reg.bpx[31]}}, sf_geo_reg.bpx}) + $signed({15'd0, sf_cxm_reg}));
            sg_pay_next.bpy_n = dpec_pkg::sat32(sf_geo_reg.dyn
                ? $signed({{8{sf_geo_reg.bpy[31]}}, sf_geo_reg.bpy}) - $signed({15'd0, sf_cym_reg})
                : $signed({{8{sf_geo_reg.bpy[31]}}, sf_geo_reg.bpy}) + $signed({15'd0, sf_cym_reg}));
        end
    end

    // ---------------- stage H: impulse set-up ----------------
    logic            sh_valid_reg;
    dpec_pkg::kpay_t sh_pay_reg, sh_pay_next;
    logic [35:0]     sh_td_reg, sh_td_next;
    logic [16:0]     sh_msum_reg;
    logic [15:0]     sh_am_reg, sh_bm_reg;
    logic [35:0]     h_dmag;

    always_comb begin
        h_dmag             = sg_dot_reg[35] ? 36'(-sg_dot_reg) : sg_dot_reg;
        sh_td_next         = {h_dmag[34:0], 1'b0};
        sh_pay_next        = sg_pay_reg;
        sh_pay_next.dotn   = sg_dot_reg[35];
        // separating or resting along the normal
        sh_pay_next.bounce = sg_pay_reg.touch && (sg_dot_reg[35] || (sg_dot_reg == '0))
                             && (sg_msum_reg != '0);
    end

    // ---------------- stage I: mass products ----------------
    logic            si_valid_reg;
    dpec_pkg::kpay_t si_pay_reg;
    logic [51:0]     si_pa_reg, si_pb_reg;
    logic [16:0]     si_msum_reg;

    // ---------------- stage J: rounding bias ----------------
    logic            sj_valid_reg;
    dpec_pkg::kpay_t sj_pay_reg;
    logic [51:0]     sj_na_reg, sj_nb_reg;
    logic [16:0]     sj_msum_reg;

    logic            kd_valid;
    logic [35:0]     kd_ka, kd_kb;
    dpec_pkg::kpay_t kd_pay;

    dpec_kdiv u_kdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sj_valid_reg),
        .in_na     (sj_na_reg),
        .in_nb     (sj_nb_reg),
        .in_msum   (sj_msum_reg),
        .in_pay    (sj_pay_reg),
        .out_valid (kd_valid),
        .out_ka    (kd_ka),
        .out_kb    (kd_kb),
        .out_pay   (kd_pay)
    );

    // ---------------- stage K: split impulse products ----------------
    logic            sk_valid_reg;
    dpec_pkg::kpay_t sk_pay_reg;
    logic [46:0]     sk_axh_reg, sk_axl_reg, sk_ayh_reg, sk_ayl_reg;
    logic [46:0]     sk_bxh_reg, sk_bxl_reg, sk_byh_reg, sk_byl_reg;

    // ---------------- stage L: partial product sum ----------------
    logic            sl_valid_reg;
    dpec_pkg::kpay_t sl_pay_reg;
    logic [64:0]     sl_ax_reg, sl_ay_reg, sl_bx_reg, sl_by_reg;

    // ---------------- stage M: rounding ----------------
    logic            sm_valid_reg;
    dpec_pkg::kpay_t sm_pay_reg;
    logic [36:0]     sm_ax_reg, sm_ay_reg, sm_bx_reg, sm_by_reg;

    localparam logic [64:0] K_HALF = 65'd1 << (dpec_pkg::NORM_FRAC - 1);

    // ---------------- stage N: velocities, output register ----------------
    logic            sn_valid_reg;
    logic [255:0]    sn_data_reg, sn_data_next;
    logic [1:0]      sn_user_reg;
    logic            n_sx, n_sy;
    logic [31:0]     n_avx, n_avy, n_bvx, n_bvy;

    always_comb begin
        n_sx  = sm_pay_reg.dotn ^ sm_pay_reg.nxn;
        n_sy  = sm_pay_reg.dotn ^ sm_pay_reg.nyn;
        n_avx = sm_pay_reg.avx;
        n_avy = sm_pay_reg.avy;
        n_bvx = sm_pay_reg.bvx;
        n_bvy = sm_pay_reg.bvy;
        if (sm_pay_reg.bounce) begin
            n_avx = dpec_pkg::sat32(n_sx
                ? $signed({{8{sm_pay_reg.avx[31]}}, sm_pay_reg.avx}) + $signed({3'd0, sm_ax_reg})
                : $signed({{8{sm_pay_reg.avx[31]}}, sm_pay_reg.avx}) - $signed({3'd0, sm_ax_reg}));
            n_avy = dpec_pkg::sat32(n_sy
                ? $signed({{8{sm_pay_reg.avy[31]}}, sm_pay_reg.avy}) + $signed({3'd0, sm_ay_reg})
                : $signed({{8{sm_pay_reg.avy[31]}}, sm_pay_reg.avy}) - $signed({3'd0, sm_ay_reg}));
            n_bvx = dpec_pkg::sat32(n_sx
                ? $signed({{8{sm_pay_reg.bvx[31]}}, sm_pay_reg.bvx}) - $signed({3'd0, sm_bx_reg})
                : $signed({{8{sm_pay_reg.bvx[31]}}, sm_pay_reg.bvx}) + $signed({3'd0, sm_bx_reg}));
            n_bvy = dpec_pkg::sat32(n_sy
                ? $signed({{8{sm_pay_reg.bvy[31]}}, sm_pay_reg.bvy}) - $signed({3'd0, sm_by_reg})
                : $signed({{8{sm_pay_reg.bvy[31]}}, sm_pay_reg.bvy}) + $signed({3'd0, sm_by_reg}));
        end
        sn_data_next = {n_bvy, n_bvx, sm_pay_reg.bpy_n, sm_pay_reg.bpx_n,
                        n_avy, n_avx, sm_pay_reg.apy_n, sm_pay_reg.apx_n};
    end

    // whole pipe moves while the output register is free or being drained
    assign en       = !sn_valid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = sn_valid_reg;
    assign m_tdata  = sn_data_reg;
    assign m_tuser  = sn_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sa_valid_reg <= 1'b0;
            sb_valid_reg <= 1'b0;
            sc_valid_reg <= 1'b0;
            sd_valid_reg <= 1'b0;
            se_valid_reg <= 1'b0;
            sf_valid_reg <= 1'b0;
            sg_valid_reg <= 1'b0;
            sh_valid_reg <= 1'b0;
            si_valid_reg <= 1'b0;
            sj_valid_reg <= 1'b0;
            sk_valid_reg <= 1'b0;
            sl_valid_reg <= 1'b0;
            sm_valid_reg <= 1'b0;
            sn_valid_reg <= 1'b0;
        end else if (en) begin
            sa_valid_reg <= s_tvalid;
            sb_valid_reg <= sa_valid_reg;
            sc_valid_reg <= sb_valid_reg;
            sd_valid_reg <= sc_valid_reg;
            se_valid_reg <= nd_valid;
            sf_valid_reg <= se_valid_reg;
            sg_valid_reg <= sf_valid_reg;
            sh_valid_reg <= sg_valid_reg;
            si_valid_reg <= sh_valid_reg;
            sj_valid_reg <= si_valid_reg;
            sk_valid_reg <= kd_valid;
            sl_valid_reg <= sk_valid_reg;
            sm_valid_reg <= sl_valid_reg;
            sn_valid_reg <= sm_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // A
            sa_geo_reg  <= sa_geo_next;
            sa_dx_reg   <= {s_bpx[31], s_bpx} - {s_apx[31], s_apx};
            sa_dy_reg   <= {s_bpy[31], s_bpy} - {s_apy[31], s_apy};
            sa_dvx_reg  <= {s_avx[31], s_avx} - {s_bvx[31], s_bvx};
            sa_dvy_reg  <= {s_avy[31], s_avy} - {s_bvy[31], s_bvy};
            sa_mind_reg <= {1'b0, s_ar} + {1'b0, s_br};
            // B
            sb_geo_reg  <= sb_geo_next;
            sb_inr_reg  <= sb_inr_next;
            // C
            sc_geo_reg   <= sb_geo_reg;
            sc_inr_reg   <= sb_inr_reg;
            sc_sqx_reg   <= {25'd0, sb_geo_reg.adx} * {25'd0, sb_geo_reg.adx};
            sc_sqy_reg   <= {25'd0, sb_geo_reg.ady} * {25'd0, sb_geo_reg.ady};
            sc_mind2_reg <= {25'd0, sb_geo_reg.mind} * {25'd0, sb_geo_reg.mind};
            // D
            sd_geo_reg <= sd_geo_next;
            sd_rad_reg <= sd_rad_next;
            // E
            se_geo_reg <= nd_geo;
            se_nxm_reg <= nd_nxm;
            se_nym_reg <= nd_nym;
            se_cxp_reg <= {29'd0, nd_geo.ovl} * {25'd0, nd_nxm};
            se_cyp_reg <= {29'd0, nd_geo.ovl} * {25'd0, nd_nym};
            se_dxp_reg <= {29'd0, nd_geo.dvxm} * {33'd0, nd_nxm};
            se_dyp_reg <= {29'd0, nd_geo.dvym} * {33'd0, nd_nym};
            // F: half the overlap, so one more fraction bit
            sf_geo_reg <= se_geo_reg;
            sf_nxm_reg <= se_nxm_reg;
            sf_nym_reg <= se_nym_reg;
            sf_cxm_reg <= 25'((se_cxp_reg + (54'd1 << dpec_pkg::NORM_FRAC))
                              >> (dpec_pkg::NORM_FRAC + 1));
            sf_cym_reg <= 25'((se_cyp_reg + (54'd1 << dpec_pkg::NORM_FRAC))
                              >> (dpec_pkg::NORM_FRAC + 1));
            sf_tx_reg  <= 34'((se_dxp_reg + (62'd1 << (dpec_pkg::NORM_FRAC - 1)))
                              >> dpec_pkg::NORM_FRAC);
            sf_ty_reg  <= 34'((se_dyp_reg + (62'd1 << (dpec_pkg::NORM_FRAC - 1)))
                              >> dpec_pkg::NORM_FRAC);
            // G
            sg_pay_reg  <= sg_pay_next;
            sg_dot_reg  <= sg_dot_next;
            sg_msum_reg <= {1'b0, sf_geo_reg.am} + {1'b0, sf_geo_reg.bm};
            sg_am_reg   <= sf_geo_reg.am;
            sg_bm_reg   <= sf_geo_reg.bm;
            // H
            sh_pay_reg  <= sh_pay_next;
            sh_td_reg   <= sh_td_next;
            sh_msum_reg <= sg_msum_reg;
            sh_am_reg   <= sg_am_reg;
            sh_bm_reg   <= sg_bm_reg;
            // I
            si_pay_reg  <= sh_pay_reg;
            si_pa_reg   <= {16'd0, sh_td_reg} * {36'd0, sh_bm_reg};
            si_pb_reg   <= {16'd0, sh_td_reg} * {36'd0, sh_am_reg};
            si_msum_reg <= sh_msum_reg;
            // J
            sj_pay_reg  <= si_pay_reg;
            sj_na_reg   <= si_pa_reg + {36'd0, si_msum_reg[16:1]};
            sj_nb_reg   <= si_pb_reg + {36'd0, si_msum_reg[16:1]};
            sj_msum_reg <= si_msum_reg;
            // K
            sk_pay_reg <= kd_pay;
            sk_axh_reg <= {29'd0, kd_ka[35:18]} * {18'd0, kd_pay.nxm};
            sk_axl_reg <= {29'd0, kd_ka[17:0]}  * {18'd0, kd_pay.nxm};
            sk_ayh_reg <= {29'd0, kd_ka[35:18]} * {18'd0, kd_pay.nym};
            sk_ayl_reg <= {29'd0, kd_ka[17:0]}  * {18'd0, kd_pay.nym};
            sk_bxh_reg <= {29'd0, kd_kb[35:18]} * {18'd0, kd_pay.nxm};
            sk_bxl_reg <= {29'd0, kd_kb[17:0]}  * {18'd0, kd_pay.nxm};
            sk_byh_reg <= {29'd0, kd_kb[35:18]} * {18'd0, kd_pay.nym};
            sk_byl_reg <= {29'd0, kd_kb[17:0]}  * {18'd0, kd_pay.nym};
            // L
            sl_pay_reg <= sk_pay_reg;
            sl_ax_reg  <= {sk_axh_reg, 18'd0} + {18'd0, sk_axl_reg};
            sl_ay_reg  <= {sk_ayh_reg, 18'd0} + {18'd0, sk_ayl_reg};
            sl_bx_reg  <= {sk_bxh_reg, 18'd0} + {18'd0, sk_bxl_reg};
            sl_by_reg  <= {sk_byh_reg, 18'd0} + {18'd0, sk_byl_reg};
            // M
            sm_pay_reg <= sl_pay_reg;
            sm_ax_reg  <= 37'((sl_ax_reg + K_HALF) >> dpec_pkg::NORM_FRAC);
            sm_ay_reg  <= 37'((sl_ay_reg + K_HALF) >> dpec_pkg::NORM_FRAC);
            sm_bx_reg  <= 37'((sl_bx_reg + K_HALF) >> dpec_pkg::NORM_FRAC);
            sm_by_reg  <= 37'((sl_by_reg + K_HALF) >> dpec_pkg::NORM_FRAC);
            // N
            sn_data_reg <= sn_data_next;
            sn_user_reg <= {sm_pay_reg.bounce, sm_pay_reg.touch};
        end
    end

endmodule
